// ===== rtl/spch_pkg.sv =====
// Shared types and constants for the superpixel centre and histogram block
`timescale 1ns / 1ps
`default_nettype none
package spch_pkg;
    localparam int MAX_SP = 256;
    localparam int MAX_BINS = 8;
    localparam int STRIDE = MAX_BINS * MAX_BINS * MAX_BINS;
    localparam int SPW = $clog2(MAX_SP);
    localparam int BW = $clog2(STRIDE);
    localparam int HAW = SPW + BW;
    localparam int HIST_DEPTH = MAX_SP * STRIDE;
    localparam logic [19:0] COUNT_MAX = 20'hFFFFF;
    localparam logic [29:0] SUM_MAX = 30'h3FFFFFFF;

    localparam logic [0:0] REG_SP_COUNT = 1'b0;
    localparam logic [0:0] REG_BINS = 1'b1;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_FINAL = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_LABEL = 2'd1,
        ST_BIN = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_PIX_RD, S_PIX_WAIT, S_PIX_WR,
        S_FIN_SP, S_FIN_SPW, S_FIN_CHK, S_FIN_RD0, S_FIN_RD1, S_FIN_WAIT, S_FIN_WR,
        S_RD_RD, S_RD_WAIT, S_RD_DIV, S_RD_DIVW, S_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [19:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [47:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/spch_divider.sv =====
// Shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module spch_divider (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire spch_pkg::div_req_t  req,
    output spch_pkg::div_rsp_t       rsp
);
    logic [47:0] quo_reg, quo_next;
    logic [19:0] rem_reg, rem_next;
    logic [19:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [20:0] trial;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[47]};
        if (req.start)
        begin
            quo_next = req.num;
            rem_next = '0;
            den_next = req.den;
            cnt_next = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 20'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial[19:0];
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo = quo_reg;
endmodule
`default_nettype wire

// ===== rtl/superpixel_center_and_color_histogram.sv =====
// Top level: sequencer, statistics stores and histogram memory
// A pixel item with a bad label is dropped. A read item runs three divisions on the
// shared divider; a bad bin index stops it after two, a bad label skips them, and the
// result waits to be taken. Finalize sums each used superpixel's bins along each axis.
// After reset a clearing pass over the stores runs before the first item is taken;
// configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module superpixel_center_and_color_histogram (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [9:0]  row,
    input  wire logic [9:0]  col,
    input  wire logic [8:0]  label,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire logic [8:0]  bin_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [17:0]      center_row,
    output logic [17:0]      center_col,
    output logic [15:0]      hist_fraction,
    output logic [19:0]      pixel_total,
    output logic [1:0]       status
);
    localparam int SPW = spch_pkg::SPW;
    localparam int BW = spch_pkg::BW;
    localparam int HAW = spch_pkg::HAW;

    logic [8:0] spc_reg;
    logic [3:0] bins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spc_reg <= 9'd256;
            bins_reg <= 4'd8;
        end
        else if (cfg_we)
        begin
            if (cfg_index == spch_pkg::REG_SP_COUNT)
                spc_reg <= cfg_data;
            else
                bins_reg <= cfg_data[3:0];
        end
    end

    logic [3:0] nb;
    logic [8:0] nsp;
    assign nb = (bins_reg == 4'd0) ? 4'd1 : (bins_reg > 4'd8) ? 4'd8 : bins_reg;
    assign nsp = (spc_reg > 9'd256) ? 9'd256 : spc_reg;

    // memories
    logic [19:0] hist_mem [spch_pkg::HIST_DEPTH];
    logic [19:0] cnt_mem [spch_pkg::MAX_SP];
    logic [29:0] rsum_mem [spch_pkg::MAX_SP];
    logic [29:0] csum_mem [spch_pkg::MAX_SP];
    logic [HAW-1:0] h_addr;
    logic [19:0] h_wdata, h_rdata;
    logic h_we;
    logic [SPW-1:0] s_addr;
    logic [19:0] c_wdata, c_rdata;
    logic [29:0] r_wdata, r_rdata, k_wdata, k_rdata;
    logic s_we;

    always_ff @(posedge clk)
    begin
        if (h_we)
            hist_mem[h_addr] <= h_wdata;
        h_rdata <= hist_mem[h_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            cnt_mem[s_addr] <= c_wdata;
            rsum_mem[s_addr] <= r_wdata;
            csum_mem[s_addr] <= k_wdata;
        end
        c_rdata <= cnt_mem[s_addr];
        r_rdata <= rsum_mem[s_addr];
        k_rdata <= csum_mem[s_addr];
    end

    spch_pkg::state_t state_reg, state_next;
    logic [HAW:0] clr_reg, clr_next;
    logic [SPW:0] sp_reg, sp_next;
    logic [1:0] axis_reg, axis_next;
    logic [3:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [19:0] prev_reg, prev_next;
    logic [BW-1:0] bin_reg, bin_next;
    logic [9:0] row_reg, row_next, col_reg, col_next;
    logic [1:0] dsel_reg, dsel_next;
    logic [19:0] cnt_reg, cnt_next;
    logic [29:0] rs_reg, rs_next, cs_reg, cs_next;
    logic [19:0] hv_reg, hv_next;
    logic [17:0] orow_reg, orow_next, ocol_reg, ocol_next;
    logic [15:0] ofr_reg, ofr_next;
    logic [1:0] ost_reg, ost_next;
    logic binbad_reg, binbad_next;
    spch_pkg::div_req_t dreq;
    spch_pkg::div_rsp_t drsp;

    spch_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    function automatic logic [2:0] quant(input logic [7:0] c, input logic [3:0] n);
        logic [11:0] q;
        q = ({4'd0, c} * {8'd0, n}) >> 8;
        if (q > {8'd0, n - 4'd1})
            q = {8'd0, n - 4'd1};
        return q[2:0];
    endfunction

    logic [8:0] nb2;
    logic [9:0] nb3;
    logic [8:0] pix_bin, cur_idx, stride_ax, step_idx;
    logic label_ok;
    assign nb2 = {5'd0, nb} * {5'd0, nb};
    assign nb3 = {1'b0, nb2} * {6'd0, nb};
    assign pix_bin = {6'd0, quant(red, nb)} + {6'd0, quant(green, nb)} * {5'd0, nb}
        + {6'd0, quant(blue, nb)} * nb2;
    assign cur_idx = {5'd0, a_reg} + {5'd0, b_reg} * {5'd0, nb} + {5'd0, c_reg} * nb2;
    assign stride_ax = (axis_reg == 2'd0) ? 9'd1 : (axis_reg == 2'd1) ? {5'd0, nb} : nb2;
    assign step_idx = cur_idx - stride_ax;
    assign label_ok = (label != 9'd0) && (label <= nsp);

    logic [20:0] hsum;
    logic [48:0] cap_q;
    assign hsum = {1'b0, h_rdata} + {1'b0, prev_reg};

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        sp_next = sp_reg;
        axis_next = axis_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        prev_next = prev_reg;
        bin_next = bin_reg;
        row_next = row_reg;
        col_next = col_reg;
        dsel_next = dsel_reg;
        cnt_next = cnt_reg;
        rs_next = rs_reg;
        cs_next = cs_reg;
        hv_next = hv_reg;
        orow_next = orow_reg;
        ocol_next = ocol_reg;
        ofr_next = ofr_reg;
        ost_next = ost_reg;
        binbad_next = binbad_reg;
        h_addr = {sp_reg[SPW-1:0], bin_reg};
        h_we = 1'b0;
        h_wdata = '0;
        s_addr = sp_reg[SPW-1:0];
        s_we = 1'b0;
        c_wdata = '0;
        r_wdata = '0;
        k_wdata = '0;
        dreq = '0;
        cap_q = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            spch_pkg::S_CLR:
            begin
                h_addr = clr_reg[HAW-1:0];
                h_we = 1'b1;
                s_addr = clr_reg[SPW-1:0];
                s_we = 1'b1;
                clr_next = clr_reg + (HAW+1)'(1);
                if (clr_reg == (HAW+1)'(spch_pkg::HIST_DEPTH - 1))
                    state_next = spch_pkg::S_IDLE;
            end
            spch_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    sp_next = (SPW+1)'(label - 9'd1);
                    bin_next = (kind == spch_pkg::KIND_PIXEL) ? pix_bin[BW-1:0] : bin_index[BW-1:0];
                    row_next = row;
                    col_next = col;
                    binbad_next = {1'b0, bin_index} >= nb3;
                    unique case (kind)
                        spch_pkg::KIND_CLEAR:
                        begin
                            clr_next = '0;
                            state_next = spch_pkg::S_CLR;
                        end
                        spch_pkg::KIND_PIXEL:
                            if (label_ok)
                                state_next = spch_pkg::S_PIX_RD;
                        spch_pkg::KIND_FINAL:
                        begin
                            sp_next = '0;
                            state_next = spch_pkg::S_FIN_SP;
                        end
                        default:
                        begin
                            if (label_ok)
                                state_next = spch_pkg::S_RD_RD;
                            else
                            begin
                                orow_next = '0;
                                ocol_next = '0;
                                ofr_next = '0;
                                ost_next = spch_pkg::ST_LABEL;
                                cnt_next = '0;
                                state_next = spch_pkg::S_OUT;
                            end
                        end
                    endcase
                end
            end
            spch_pkg::S_PIX_RD:
                state_next = spch_pkg::S_PIX_WAIT;
            spch_pkg::S_PIX_WAIT:
                state_next = spch_pkg::S_PIX_WR;
            spch_pkg::S_PIX_WR:
            begin
                state_next = spch_pkg::S_IDLE;
                if (c_rdata != spch_pkg::COUNT_MAX)
                begin
                    s_we = 1'b1;
                    c_wdata = c_rdata + 20'd1;
                    r_wdata = ({1'b0, r_rdata} + 31'(row_reg) > {1'b0, spch_pkg::SUM_MAX})
                        ? spch_pkg::SUM_MAX : r_rdata + 30'(row_reg);
                    k_wdata = ({1'b0, k_rdata} + 31'(col_reg) > {1'b0, spch_pkg::SUM_MAX})
                        ? spch_pkg::SUM_MAX : k_rdata + 30'(col_reg);
                    h_we = 1'b1;
                    h_wdata = (h_rdata == spch_pkg::COUNT_MAX) ? h_rdata : h_rdata + 20'd1;
                end
            end
            spch_pkg::S_FIN_SP:
            begin
                axis_next = '0;
                a_next = '0;
                b_next = '0;
                c_next = '0;
                state_next = spch_pkg::S_FIN_SPW;
            end
            spch_pkg::S_FIN_SPW:
                state_next = spch_pkg::S_FIN_CHK;
            spch_pkg::S_FIN_CHK:
            begin
                if (c_rdata == 20'd0 || nb == 4'd1)
                begin
                    sp_next = sp_reg + (SPW+1)'(1);
                    state_next = (sp_reg == (SPW+1)'(spch_pkg::MAX_SP - 1))
                        ? spch_pkg::S_IDLE : spch_pkg::S_FIN_SP;
                end
                else
                begin
                    a_next = 4'd1;
                    state_next = spch_pkg::S_FIN_RD0;
                end
            end
            spch_pkg::S_FIN_RD0:
            begin
                h_addr = {sp_reg[SPW-1:0], step_idx[BW-1:0]};
                state_next = spch_pkg::S_FIN_RD1;
            end
            spch_pkg::S_FIN_RD1:
            begin
                h_addr = {sp_reg[SPW-1:0], cur_idx[BW-1:0]};
                prev_next = h_rdata;
                state_next = spch_pkg::S_FIN_WAIT;
            end
            spch_pkg::S_FIN_WAIT:
            begin
                h_addr = {sp_reg[SPW-1:0], cur_idx[BW-1:0]};
                state_next = spch_pkg::S_FIN_WR;
            end
            spch_pkg::S_FIN_WR:
            begin
                h_addr = {sp_reg[SPW-1:0], cur_idx[BW-1:0]};
                h_we = 1'b1;
                h_wdata = hsum[20] ? spch_pkg::COUNT_MAX : hsum[19:0];
                state_next = spch_pkg::S_FIN_RD0;
                // advance a fastest, then b, then c; start of range depends on axis
                if (a_reg != nb - 4'd1)
                    a_next = a_reg + 4'd1;
                else
                begin
                    a_next = (axis_reg == 2'd0) ? 4'd1 : 4'd0;
                    if (b_reg != nb - 4'd1)
                        b_next = b_reg + 4'd1;
                    else
                    begin
                        b_next = (axis_reg == 2'd1) ? 4'd1 : 4'd0;
                        if (c_reg != nb - 4'd1)
                            c_next = c_reg + 4'd1;
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                            a_next = 4'd0;
                            b_next = (axis_reg == 2'd0) ? 4'd1 : 4'd0;
                            c_next = (axis_reg == 2'd1) ? 4'd1 : 4'd0;
                            if (axis_reg == 2'd2)
                            begin
                                sp_next = sp_reg + (SPW+1)'(1);
                                state_next = (sp_reg == (SPW+1)'(spch_pkg::MAX_SP - 1))
                                    ? spch_pkg::S_IDLE : spch_pkg::S_FIN_SP;
                            end
                        end
                    end
                end
            end
            spch_pkg::S_RD_RD:
                state_next = spch_pkg::S_RD_WAIT;
            spch_pkg::S_RD_WAIT:
            begin
                cnt_next = c_rdata;
                rs_next = r_rdata;
                cs_next = k_rdata;
                hv_next = h_rdata;
                dsel_next = '0;
                state_next = spch_pkg::S_RD_DIV;
            end
            spch_pkg::S_RD_DIV:
            begin
                dreq.start = 1'b1;
                dreq.den = cnt_reg;
                dreq.num = (dsel_reg == 2'd0) ? {10'd0, rs_reg, 8'd0}
                    : (dsel_reg == 2'd1) ? {10'd0, cs_reg, 8'd0} : {12'd0, hv_reg, 16'd0};
                state_next = spch_pkg::S_RD_DIVW;
            end
            spch_pkg::S_RD_DIVW:
            begin
                if (drsp.done)
                begin
                    cap_q = (cnt_reg == 20'd0) ? 49'd0 : {1'b0, drsp.quo};
                    dsel_next = dsel_reg + 2'd1;
                    state_next = spch_pkg::S_RD_DIV;
                    if (dsel_reg == 2'd0)
                        orow_next = (cap_q > 49'h3FFFF) ? 18'h3FFFF : cap_q[17:0];
                    else if (dsel_reg == 2'd1)
                    begin
                        ocol_next = (cap_q > 49'h3FFFF) ? 18'h3FFFF : cap_q[17:0];
                        if (binbad_reg)
                        begin
                            ofr_next = '0;
                            ost_next = spch_pkg::ST_BIN;
                            state_next = spch_pkg::S_OUT;
                        end
                    end
                    else
                    begin
                        ofr_next = (cap_q > 49'hFFFF) ? 16'hFFFF : cap_q[15:0];
                        ost_next = spch_pkg::ST_OK;
                        state_next = spch_pkg::S_OUT;
                    end
                end
            end
            spch_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = spch_pkg::S_IDLE;
            end
            default:
                state_next = spch_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spch_pkg::S_CLR;
            clr_reg <= '0;
            sp_reg <= '0;
            axis_reg <= '0;
            dsel_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            sp_reg <= sp_next;
            axis_reg <= axis_next;
            dsel_reg <= dsel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        prev_reg <= prev_next;
        bin_reg <= bin_next;
        row_reg <= row_next;
        col_reg <= col_next;
        cnt_reg <= cnt_next;
        rs_reg <= rs_next;
        cs_reg <= cs_next;
        hv_reg <= hv_next;
        orow_reg <= orow_next;
        ocol_reg <= ocol_next;
        ofr_reg <= ofr_next;
        ost_reg <= ost_next;
        binbad_reg <= binbad_next;
    end

    assign center_row = orow_reg;
    assign center_col = ocol_reg;
    assign hist_fraction = ofr_reg;
    assign pixel_total = cnt_reg;
    assign status = ost_reg;
endmodule
`default_nettype wire

// ===== rtl/spch_checker.sv =====
// Port-level checks for the superpixel block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module spch_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [17:0] center_row,
    input wire logic [15:0] hist_fraction,
    input wire logic [19:0] pixel_total,
    input wire logic [1:0]  status
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(center_row))
        else $error("result dropped");
    a_bad_label: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == spch_pkg::ST_LABEL |-> pixel_total == 20'd0 && center_row == 18'd0)
        else $error("bad label result not zero");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_total == 20'd0 |-> hist_fraction == 16'd0)
        else $error("empty superpixel fraction");
endmodule

bind superpixel_center_and_color_histogram spch_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .center_row(center_row),
    .hist_fraction(hist_fraction), .pixel_total(pixel_total), .status(status)
);
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for the superpixel centre and colour histogram block
`timescale 1ns / 1ps
module tb_top;
    localparam int LIMIT_CYCLES = 6000000;

    typedef struct {
        logic [17:0] c_row;
        logic [17:0] c_col;
        logic [15:0] frac;
        logic [19:0] total;
        logic [1:0]  stat;
    } descriptor_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind = '0;
    logic [9:0]  row = '0;
    logic [9:0]  col = '0;
    logic [8:0]  label = '0;
    logic [7:0]  red = '0;
    logic [7:0]  green = '0;
    logic [7:0]  blue = '0;
    logic [8:0]  bin_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [17:0] center_row;
    logic [17:0] center_col;
    logic [15:0] hist_fraction;
    logic [19:0] pixel_total;
    logic [1:0]  status;

    superpixel_center_and_color_histogram DUT (.*);

    always #5 clk = ~clk;

    // predictor state
    int unsigned sp_count_reg;
    int unsigned bins_reg;
    int unsigned counts [spch_pkg::MAX_SP];
    int unsigned row_acc [spch_pkg::MAX_SP];
    int unsigned col_acc [spch_pkg::MAX_SP];
    int unsigned hist [spch_pkg::HIST_DEPTH];

    descriptor_t expected_descriptors [$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    longint      cycle_count = 0;

    function automatic int unsigned eff_bins();
        if (bins_reg == 0)
            return 1;
        if (bins_reg > spch_pkg::MAX_BINS)
            return spch_pkg::MAX_BINS;
        return bins_reg;
    endfunction

    function automatic bit label_valid(int unsigned lb);
        int unsigned n;
        n = (sp_count_reg > spch_pkg::MAX_SP) ? spch_pkg::MAX_SP : sp_count_reg;
        return lb >= 1 && lb <= n;
    endfunction

    function automatic int unsigned quantise(int unsigned c, int unsigned nb);
        int unsigned q;
        q = (c * nb) >> 8;
        return (q > nb - 1) ? nb - 1 : q;
    endfunction

    function automatic int unsigned sat_add(int unsigned a, int unsigned b,
                                            int unsigned cap);
        longint unsigned s;
        s = longint'(a) + longint'(b);
        return (s > cap) ? cap : int'(s);
    endfunction

    function automatic longint unsigned ratio(longint unsigned num, int sh,
                                              longint unsigned den,
                                              longint unsigned cap);
        longint unsigned q;
        if (den == 0)
            return 0;
        q = (num << sh) / den;
        return (q > cap) ? cap : q;
    endfunction

    function automatic void cumulate_histograms();
        int unsigned nb;
        int unsigned base;
        int unsigned i;
        nb = eff_bins();
        for (int sp = 0; sp < spch_pkg::MAX_SP; sp++)
        begin
            if (counts[sp] == 0)
                continue;
            base = sp * spch_pkg::STRIDE;
            for (int c = 0; c < nb; c++)
                for (int b = 0; b < nb; b++)
                    for (int a = 1; a < nb; a++)
                    begin
                        i = base + a + b * nb + c * nb * nb;
                        hist[i] = sat_add(hist[i], hist[i - 1], spch_pkg::COUNT_MAX);
                    end
            for (int c = 0; c < nb; c++)
                for (int b = 1; b < nb; b++)
                    for (int a = 0; a < nb; a++)
                    begin
                        i = base + a + b * nb + c * nb * nb;
                        hist[i] = sat_add(hist[i], hist[i - nb], spch_pkg::COUNT_MAX);
                    end
            for (int c = 1; c < nb; c++)
                for (int b = 0; b < nb; b++)
                    for (int a = 0; a < nb; a++)
                    begin
                        i = base + a + b * nb + c * nb * nb;
                        hist[i] = sat_add(hist[i], hist[i - nb * nb], spch_pkg::COUNT_MAX);
                    end
        end
    endfunction

    function automatic void clear_store();
        foreach (counts[i])
        begin
            counts[i] = 0;
            row_acc[i] = 0;
            col_acc[i] = 0;
        end
        foreach (hist[i])
            hist[i] = 0;
    endfunction

    function automatic void predict_item(spch_pkg::kind_t k, int unsigned r, int unsigned c,
                                         int unsigned lb, int unsigned rd,
                                         int unsigned gr, int unsigned bl,
                                         int unsigned bi);
        int unsigned nb;
        int unsigned sp;
        int unsigned bin;
        descriptor_t d;
        nb = eff_bins();
        case (k)
            spch_pkg::KIND_CLEAR:
                clear_store();
            spch_pkg::KIND_PIXEL:
            begin
                if (label_valid(lb) && r < 1024 && c < 1024)
                begin
                    sp = lb - 1;
                    if (counts[sp] < spch_pkg::COUNT_MAX)
                    begin
                        counts[sp]++;
                        row_acc[sp] = sat_add(row_acc[sp], r, spch_pkg::SUM_MAX);
                        col_acc[sp] = sat_add(col_acc[sp], c, spch_pkg::SUM_MAX);
                        bin = quantise(rd, nb) + quantise(gr, nb) * nb
                            + quantise(bl, nb) * nb * nb;
                        hist[sp * spch_pkg::STRIDE + bin] =
                            sat_add(hist[sp * spch_pkg::STRIDE + bin], 1, spch_pkg::COUNT_MAX);
                    end
                end
            end
            spch_pkg::KIND_FINAL:
                cumulate_histograms();
            default:
            begin
                d = '{0, 0, 0, 0, spch_pkg::ST_OK};
                if (!label_valid(lb))
                begin
                    d.stat = spch_pkg::ST_LABEL;
                end
                else
                begin
                    sp = lb - 1;
                    d.c_row = ratio(row_acc[sp], 8, counts[sp], 18'h3FFFF);
                    d.c_col = ratio(col_acc[sp], 8, counts[sp], 18'h3FFFF);
                    d.total = counts[sp];
                    if (bi >= nb * nb * nb)
                        d.stat = spch_pkg::ST_BIN;
                    else
                        d.frac = ratio(hist[sp * spch_pkg::STRIDE + bi], 16, counts[sp],
                                       16'hFFFF);
                end
                expected_descriptors.push_back(d);
            end
        endcase
    endfunction

    task automatic send_item(spch_pkg::kind_t k, int unsigned r, int unsigned c,
                             int unsigned lb, int unsigned rd, int unsigned gr,
                             int unsigned bl, int unsigned bi);
        kind <= k;
        row <= r;
        col <= c;
        label <= lb;
        red <= rd;
        green <= gr;
        blue <= bl;
        bin_index <= bi;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(k, r, c, lb, rd, gr, bl, bi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_read(int unsigned lb, int unsigned bi);
        send_item(spch_pkg::KIND_READ, 0, 0, lb, 0, 0, 0, bi);
    endtask

    task automatic send_pixel(int unsigned r, int unsigned c, int unsigned lb,
                              int unsigned rd, int unsigned gr, int unsigned bl);
        send_item(spch_pkg::KIND_PIXEL, r, c, lb, rd, gr, bl, 0);
    endtask

    // trailing read proves all earlier items are done
    task automatic drain();
        send_read(1, 0);
        in_valid <= 1'b0;
        while (expected_descriptors.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, int unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == spch_pkg::REG_SP_COUNT)
            sp_count_reg = value & 9'h1FF;
        else
            bins_reg = value & 4'hF;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        descriptor_t d;
        if (out_valid && out_ready)
        begin
            if (expected_descriptors.size() == 0)
            begin
                $display("%0t: unexpected item, status %0d", $time, status);
                error_count++;
            end
            else
            begin
                d = expected_descriptors.pop_front();
                if (center_row !== d.c_row || center_col !== d.c_col ||
                    hist_fraction !== d.frac || pixel_total !== d.total ||
                    status !== d.stat)
                begin
                    $display("%0t: mismatch exp row %0d col %0d frac %0d total %0d st %0d",
                             $time, d.c_row, d.c_col, d.frac, d.total, d.stat);
                    $display("%0t:          got row %0d col %0d frac %0d total %0d st %0d",
                             $time, center_row, center_col, hist_fraction,
                             pixel_total, status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic test_directed();
        write_reg(spch_pkg::REG_SP_COUNT, 256);
        write_reg(spch_pkg::REG_BINS, 8);
        send_pixel(0, 0, 1, 0, 0, 0);
        send_pixel(1023, 1023, 256, 255, 255, 255);
        send_pixel(5, 7, 1, 128, 64, 200);
        send_pixel(10, 10, 0, 1, 1, 1);
        send_pixel(10, 10, 257, 1, 1, 1);
        send_pixel(10, 10, 511, 1, 1, 1);
        send_read(1, 0);
        send_read(256, 511);
        send_read(0, 0);
        send_read(300, 0);
        send_read(5, 3);
        send_item(spch_pkg::KIND_FINAL, 0, 0, 0, 0, 0, 0, 0);
        send_read(1, 511);
        send_read(256, 511);
        repeat (4) send_item(spch_pkg::KIND_FINAL, 0, 0, 0, 0, 0, 0, 0);
        send_read(1, 511);
        send_read(1, 300);
        send_item(spch_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        send_read(1, 0);
        send_read(256, 0);
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(spch_pkg::REG_SP_COUNT, 0);
        send_pixel(3, 4, 1, 9, 9, 9);
        send_read(1, 0);
        drain();
        write_reg(spch_pkg::REG_SP_COUNT, 511);
        write_reg(spch_pkg::REG_BINS, 0);
        send_pixel(3, 4, 256, 255, 0, 255);
        send_read(256, 0);
        send_read(256, 1);
        drain();
        write_reg(spch_pkg::REG_BINS, 15);
        send_pixel(8, 9, 2, 200, 100, 50);
        send_read(2, 511);
        send_read(256, 0);
        drain();
        write_reg(spch_pkg::REG_BINS, 3);
        send_pixel(8, 9, 2, 170, 171, 85);
        send_read(2, 26);
        send_read(2, 27);
        drain();
    endtask

    task automatic test_random(int idle_pct, int stall_pct, int unsigned sp_n,
                               int unsigned nb, int n);
        int unsigned lb;
        int unsigned pick;
        int unsigned nbins;
        write_reg(spch_pkg::REG_SP_COUNT, sp_n);
        write_reg(spch_pkg::REG_BINS, nb);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        nbins = eff_bins() ** 3;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(999);
            if ($urandom_range(19) == 0)
                lb = $urandom_range(511);
            else
                lb = $urandom_range(sp_n + 1);
            if (pick < 3)
                send_item(spch_pkg::KIND_FINAL, $urandom, $urandom, lb, $urandom,
                          $urandom, $urandom, $urandom);
            else if (pick < 250)
                send_item(spch_pkg::KIND_READ, $urandom, $urandom, lb, $urandom, $urandom,
                          $urandom, ($urandom_range(9) == 0) ? $urandom_range(511)
                                                             : $urandom_range(nbins - 1));
            else
                send_item(spch_pkg::KIND_PIXEL, $urandom_range(1023), $urandom_range(1023),
                          lb, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                          $urandom_range(511));
        end
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 600;
        for (int i = 0; i < 30; i++)
            send_read($urandom_range(4, 1), $urandom_range(63));
        drain();
    endtask

    initial
    begin
        sp_count_reg = 256;
        bins_reg = 8;
        clear_store();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        send_item(spch_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        drain();
        test_random(0, 0, 8, 8, 350);
        test_random(52, 0, 1, 4, 350);
        test_random(0, 52, 16, 2, 350);
        test_random(7, 7, 4, 8, 350);
        test_backpressure();
        in_valid <= 1'b0;
        while (expected_descriptors.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
